### design/pop_pkg.sv
`timescale 1ns / 1ps
// pop_pkg: shared widths, stage record types and step functions for the
// plane projection pipeline. No dependencies.
`default_nettype none
package pop_pkg;

    localparam int WORD_BITS_DEF = 32;

    localparam int NORM_BITS = 30;
    localparam int NORM_TOP  = 29;
    localparam int SQ_STEPS  = 32;
    localparam int SQ_REM_W  = 35;
    localparam int DIV_STEPS = 33;
    localparam int NUM_W     = 63;
    localparam int DIVR_W    = 31;

    typedef logic [NORM_BITS-1:0] nmag_t;
    typedef logic signed [NORM_BITS:0] nval_t;

    typedef struct packed {
        logic             ok;
        logic [2:0]       neg;
        nmag_t [2:0]      mag;
    } dir_t;

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [31:0]         root;
        logic [63:0]         rad;
    } sq_t;

    typedef struct packed {
        logic [DIVR_W-1:0]    rem;
        logic [DIV_STEPS-1:0] quo;
        logic [NUM_W-1:0]     num;
    } dv_t;

    function automatic logic [5:0] lead64(input logic [63:0] m);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (m[i])
            begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

    function automatic nmag_t norm_mag(input logic [63:0] m, input logic [5:0] p);
        logic [63:0] t;
        if (p >= 6'(NORM_TOP))
        begin
            t = m >> (p - 6'(NORM_TOP));
        end
        else
        begin
            t = m << (6'(NORM_TOP) - p);
        end
        return t[NORM_BITS-1:0];
    endfunction

    function automatic nval_t to_signed(input nmag_t m, input logic neg);
        logic [NORM_BITS:0] u;
        u = {1'b0, m};
        if (neg)
        begin
            u = ~u + 1'b1;
        end
        return $signed(u);
    endfunction

    // one result bit of the restoring square root
    function automatic sq_t sq_step(input sq_t s);
        logic [SQ_REM_W-1:0] rt;
        logic [SQ_REM_W-1:0] tr;
        sq_t o;
        rt    = {s.rem[SQ_REM_W-3:0], s.rad[63:62]};
        tr    = {1'b0, s.root, 2'b01};
        o.rad = s.rad << 2;
        if (rt >= tr)
        begin
            o.rem  = rt - tr;
            o.root = {s.root[30:0], 1'b1};
        end
        else
        begin
            o.rem  = rt;
            o.root = {s.root[30:0], 1'b0};
        end
        return o;
    endfunction

    // one quotient bit of the restoring division
    function automatic dv_t dv_step(input dv_t s, input logic [DIVR_W-1:0] dvs);
        logic [DIVR_W:0] rt;
        dv_t o;
        rt    = {s.rem, s.num[NUM_W-1]};
        o.num = s.num << 1;
        if (rt >= {1'b0, dvs})
        begin
            o.rem = DIVR_W'(rt - {1'b0, dvs});
            o.quo = {s.quo[DIV_STEPS-2:0], 1'b1};
        end
        else
        begin
            o.rem = rt[DIVR_W-1:0];
            o.quo = {s.quo[DIV_STEPS-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage
`default_nettype wire

### design/project_onto_plane_top.sv
`timescale 1ns / 1ps
// project_onto_plane_top: length-preserving projection of a vector onto a plane.
// Depends on pop_pkg.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------
//  request   | start / busy       | vec_x/y/z, normal_x/y/z
//  result    | done (one cycle)   | proj_x/y/z, degenerate
//
// 81-stage pipeline, one request per clock. done rises together with proj_x/y/z
// and degenerate, which are registered in the last stage.
// Depth is set by the 32 root stages and 33 quotient stages.
// busy is held low; results cannot be stalled.
// rst_n clears the valid bits only; nothing else needs clearing.
`default_nettype none
module project_onto_plane_top
    import pop_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        start,
    output logic                       busy,
    input  wire signed [WORD_BITS-1:0] vec_x,
    input  wire signed [WORD_BITS-1:0] vec_y,
    input  wire signed [WORD_BITS-1:0] vec_z,
    input  wire signed [WORD_BITS-1:0] normal_x,
    input  wire signed [WORD_BITS-1:0] normal_y,
    input  wire signed [WORD_BITS-1:0] normal_z,
    output logic                       done,
    output logic signed [WORD_BITS-1:0] proj_x,
    output logic signed [WORD_BITS-1:0] proj_y,
    output logic signed [WORD_BITS-1:0] proj_z,
    output logic                       degenerate
);

    localparam int W      = WORD_BITS;
    localparam int SW     = $clog2(WORD_BITS);
    localparam int NSTAGE = 13 + SQ_STEPS + 2 + DIV_STEPS + 1;
    localparam logic [63:0] POS_LIM = (64'd1 << (W - 1)) - 64'd1;
    localparam logic [63:0] NEG_LIM = 64'd1 << (W - 1);

    logic [NSTAGE-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NSTAGE-2:0], start};
        end
    end

    assign busy = 1'b0;
    assign done = vld_reg[NSTAGE-1];

    // s1: magnitudes
    logic [W-1:0] vm1_reg [3];
    logic [W-1:0] nm1_reg [3];
    logic [2:0]   vn1_reg, nn1_reg;
    logic signed [W-1:0] vin [3];
    logic signed [W-1:0] nin [3];

    assign vin[0] = vec_x;
    assign vin[1] = vec_y;
    assign vin[2] = vec_z;
    assign nin[0] = normal_x;
    assign nin[1] = normal_y;
    assign nin[2] = normal_z;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            vm1_reg[i] <= vin[i][W-1] ? W'(-vin[i]) : W'(vin[i]);
            nm1_reg[i] <= nin[i][W-1] ? W'(-nin[i]) : W'(nin[i]);
            vn1_reg[i] <= vin[i][W-1];
            nn1_reg[i] <= nin[i][W-1];
        end
    end

    // s2: leading one, largest magnitude of v
    logic [W-1:0] vm2_reg [3];
    logic [W-1:0] nm2_reg [3];
    logic [2:0]   vn2_reg, nn2_reg;
    logic [5:0]   pa2_reg, pb2_reg;
    logic [W-1:0] vmax2_reg;
    logic         ok2_reg;
    logic [W-1:0] vor1, nor1, vmx01;

    assign vor1  = vm1_reg[0] | vm1_reg[1] | vm1_reg[2];
    assign nor1  = nm1_reg[0] | nm1_reg[1] | nm1_reg[2];
    assign vmx01 = (vm1_reg[0] > vm1_reg[1]) ? vm1_reg[0] : vm1_reg[1];

    always_ff @(posedge clk)
    begin
        vm2_reg   <= vm1_reg;
        nm2_reg   <= nm1_reg;
        vn2_reg   <= vn1_reg;
        nn2_reg   <= nn1_reg;
        pa2_reg   <= lead64(64'(vor1));
        pb2_reg   <= lead64(64'(nor1));
        vmax2_reg <= (vmx01 > vm1_reg[2]) ? vmx01 : vm1_reg[2];
        ok2_reg   <= (|vor1) & (|nor1);
    end

    // s3: normalized a and b, length shift s
    nval_t        a3_reg [3];
    nval_t        b3_reg [3];
    logic [W-1:0] vm3_reg [3];
    logic [SW-1:0] s3_reg;
    logic         ok3_reg;
    logic [SW-1:0] s_next;
    logic [63:0]  vt;
    logic [5:0]   vk;

    always_comb
    begin
        vk = pa2_reg - 6'd31;
        vt = 64'(vmax2_reg) >> vk;
        if (pa2_reg < 6'd31)
        begin
            s_next = '0;
        end
        else
        begin
            s_next = SW'(vk + 6'(vt[30:0] != '0));
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            a3_reg[i] <= to_signed(norm_mag(64'(vm2_reg[i]), pa2_reg), vn2_reg[i]);
            b3_reg[i] <= to_signed(norm_mag(64'(nm2_reg[i]), pb2_reg), nn2_reg[i]);
        end
        vm3_reg <= vm2_reg;
        s3_reg  <= s_next;
        ok3_reg <= ok2_reg;
    end

    // s4: a x b products
    logic signed [61:0] p4_reg [6];
    nval_t        b4_reg [3];
    logic [31:0]  vs4_reg [3];
    logic [SW-1:0] s4_reg;
    logic         ok4_reg;

    always_ff @(posedge clk)
    begin
        p4_reg[0] <= a3_reg[1] * b3_reg[2];
        p4_reg[1] <= a3_reg[2] * b3_reg[1];
        p4_reg[2] <= a3_reg[2] * b3_reg[0];
        p4_reg[3] <= a3_reg[0] * b3_reg[2];
        p4_reg[4] <= a3_reg[0] * b3_reg[1];
        p4_reg[5] <= a3_reg[1] * b3_reg[0];
        for (int i = 0; i < 3; i++)
        begin
            vs4_reg[i] <= 32'(64'(vm3_reg[i]) >> s3_reg);
        end
        b4_reg  <= b3_reg;
        s4_reg  <= s3_reg;
        ok4_reg <= ok3_reg;
    end

    // s5: c = a x b
    logic signed [61:0] c5_reg [3];
    nval_t        b5_reg [3];
    logic [31:0]  vs5_reg [3];
    logic [SW-1:0] s5_reg;
    logic         ok5_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            c5_reg[i] <= p4_reg[2*i] - p4_reg[2*i+1];
        end
        b5_reg  <= b4_reg;
        vs5_reg <= vs4_reg;
        s5_reg  <= s4_reg;
        ok5_reg <= ok4_reg;
    end

    // s6: c magnitudes and leading one
    logic [63:0]  cm6_reg [3];
    logic [2:0]   cn6_reg;
    logic [5:0]   pc6_reg;
    nval_t        b6_reg [3];
    logic [31:0]  vs6_reg [3];
    logic [SW-1:0] s6_reg;
    logic         ok6_reg;
    logic [63:0]  cm5 [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cm5[i] = 64'(c5_reg[i][61] ? 62'(-c5_reg[i]) : 62'(c5_reg[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            cm6_reg[i] <= cm5[i];
            cn6_reg[i] <= c5_reg[i][61];
        end
        pc6_reg <= lead64(cm5[0] | cm5[1] | cm5[2]);
        ok6_reg <= ok5_reg & ((|cm5[0]) | (|cm5[1]) | (|cm5[2]));
        b6_reg  <= b5_reg;
        vs6_reg <= vs5_reg;
        s6_reg  <= s5_reg;
    end

    // s7: normalized c
    nval_t        c7_reg [3];
    nval_t        b7_reg [3];
    logic [31:0]  vs7_reg [3];
    logic [SW-1:0] s7_reg;
    logic         ok7_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            c7_reg[i] <= to_signed(norm_mag(cm6_reg[i], pc6_reg), cn6_reg[i]);
        end
        b7_reg  <= b6_reg;
        vs7_reg <= vs6_reg;
        s7_reg  <= s6_reg;
        ok7_reg <= ok6_reg;
    end

    // s8: b x c products
    logic signed [61:0] p8_reg [6];
    logic [31:0]  vs8_reg [3];
    logic [SW-1:0] s8_reg;
    logic         ok8_reg;

    always_ff @(posedge clk)
    begin
        p8_reg[0] <= b7_reg[1] * c7_reg[2];
        p8_reg[1] <= b7_reg[2] * c7_reg[1];
        p8_reg[2] <= b7_reg[2] * c7_reg[0];
        p8_reg[3] <= b7_reg[0] * c7_reg[2];
        p8_reg[4] <= b7_reg[0] * c7_reg[1];
        p8_reg[5] <= b7_reg[1] * c7_reg[0];
        vs8_reg <= vs7_reg;
        s8_reg  <= s7_reg;
        ok8_reg <= ok7_reg;
    end

    // s9: d = b x c
    logic signed [61:0] d9_reg [3];
    logic [31:0]  vs9_reg [3];
    logic [SW-1:0] s9_reg;
    logic         ok9_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            d9_reg[i] <= p8_reg[2*i] - p8_reg[2*i+1];
        end
        vs9_reg <= vs8_reg;
        s9_reg  <= s8_reg;
        ok9_reg <= ok8_reg;
    end

    // s10: d magnitudes and leading one
    logic [63:0]  dm10_reg [3];
    logic [2:0]   dn10_reg;
    logic [5:0]   pd10_reg;
    logic [31:0]  vs10_reg [3];
    logic [SW-1:0] s10_reg;
    logic         ok10_reg;
    logic [63:0]  dm9 [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dm9[i] = 64'(d9_reg[i][61] ? 62'(-d9_reg[i]) : 62'(d9_reg[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            dm10_reg[i] <= dm9[i];
            dn10_reg[i] <= d9_reg[i][61];
        end
        pd10_reg <= lead64(dm9[0] | dm9[1] | dm9[2]);
        ok10_reg <= ok9_reg & ((|dm9[0]) | (|dm9[1]) | (|dm9[2]));
        vs10_reg <= vs9_reg;
        s10_reg  <= s9_reg;
    end

    // s11: normalized d
    dir_t         d11_reg;
    logic [31:0]  vs11_reg [3];
    logic [SW-1:0] s11_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            d11_reg.mag[i] <= norm_mag(dm10_reg[i], pd10_reg);
        end
        d11_reg.neg <= dn10_reg;
        d11_reg.ok  <= ok10_reg;
        vs11_reg    <= vs10_reg;
        s11_reg     <= s10_reg;
    end

    // s12: squares
    logic [59:0]  dq12_reg [3];
    logic [63:0]  vq12_reg [3];
    dir_t         d12_reg;
    logic [SW-1:0] s12_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            dq12_reg[i] <= d11_reg.mag[i] * d11_reg.mag[i];
            vq12_reg[i] <= vs11_reg[i] * vs11_reg[i];
        end
        d12_reg <= d11_reg;
        s12_reg <= s11_reg;
    end

    // s13 .. s45: root lanes (0: d.d, 1: v.v)
    sq_t          sq_reg [SQ_STEPS+1][2];
    dir_t         dq_reg [SQ_STEPS+1];
    logic [SW-1:0] sq_s_reg [SQ_STEPS+1];

    always_ff @(posedge clk)
    begin
        sq_reg[0][0].rem  <= '0;
        sq_reg[0][0].root <= '0;
        sq_reg[0][0].rad  <= 64'(dq12_reg[0]) + 64'(dq12_reg[1]) + 64'(dq12_reg[2]);
        sq_reg[0][1].rem  <= '0;
        sq_reg[0][1].root <= '0;
        sq_reg[0][1].rad  <= vq12_reg[0] + vq12_reg[1] + vq12_reg[2];
        dq_reg[0]         <= d12_reg;
        sq_s_reg[0]       <= s12_reg;
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            sq_reg[k+1][0] <= sq_step(sq_reg[k][0]);
            sq_reg[k+1][1] <= sq_step(sq_reg[k][1]);
            dq_reg[k+1]    <= dq_reg[k];
            sq_s_reg[k+1]  <= sq_s_reg[k];
        end
    end

    // s46: |d_i| * lenv
    logic [61:0]  pm46_reg [3];
    logic [DIVR_W-1:0] lend46_reg;
    dir_t         d46_reg;
    logic [SW-1:0] s46_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            pm46_reg[i] <= dq_reg[SQ_STEPS].mag[i] * sq_reg[SQ_STEPS][1].root;
        end
        lend46_reg <= sq_reg[SQ_STEPS][0].root[DIVR_W-1:0];
        d46_reg    <= dq_reg[SQ_STEPS];
        s46_reg    <= sq_s_reg[SQ_STEPS];
    end

    // s47 .. s80: rounded division by lend
    dv_t          dv_reg [DIV_STEPS+1][3];
    logic [DIVR_W-1:0] lend_reg [DIV_STEPS+1];
    dir_t         dd_reg [DIV_STEPS+1];
    logic [SW-1:0] dv_s_reg [DIV_STEPS+1];
    logic [NUM_W-1:0] num46 [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num46[i] = NUM_W'(pm46_reg[i]) + NUM_W'(lend46_reg >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            dv_reg[0][i].rem <= {1'b0, num46[i][NUM_W-1:DIV_STEPS]};
            dv_reg[0][i].quo <= '0;
            dv_reg[0][i].num <= num46[i] << (NUM_W - DIV_STEPS);
        end
        lend_reg[0] <= lend46_reg;
        dd_reg[0]   <= d46_reg;
        dv_s_reg[0] <= s46_reg;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv_reg[k+1][i] <= dv_step(dv_reg[k][i], lend_reg[k]);
            end
            lend_reg[k+1] <= lend_reg[k];
            dd_reg[k+1]   <= dd_reg[k];
            dv_s_reg[k+1] <= dv_s_reg[k];
        end
    end

    // s81: scale back, sign, saturate
    logic [W-1:0] out_reg [3];
    logic         deg_reg;
    logic [63:0]  sh [3];
    logic [63:0]  lim [3];
    logic [W-1:0] res [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sh[i] = 64'(dv_reg[DIV_STEPS][i].quo) << dv_s_reg[DIV_STEPS];
            if (dd_reg[DIV_STEPS].neg[i])
            begin
                lim[i] = (sh[i] > NEG_LIM) ? NEG_LIM : sh[i];
                res[i] = W'(64'd0 - lim[i]);
            end
            else
            begin
                lim[i] = (sh[i] > POS_LIM) ? POS_LIM : sh[i];
                res[i] = W'(lim[i]);
            end
            if (!dd_reg[DIV_STEPS].ok)
            begin
                res[i] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= res;
        deg_reg <= ~dd_reg[DIV_STEPS].ok;
    end

    assign proj_x     = $signed(out_reg[0]);
    assign proj_y     = $signed(out_reg[1]);
    assign proj_z     = $signed(out_reg[2]);
    assign degenerate = deg_reg;

endmodule
`default_nettype wire
